@@ rtl/kst_pkg.sv @@
package kst_pkg;

   localparam int FIFO_DEPTH = 128;
   localparam int TABLE_LEN  = 88;

   localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
   localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
   localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
   localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
   localparam logic [7:0] SC_BREAK_BIT    = 8'h80;

   localparam logic CMD_SCANCODE = 1'b0;
   localparam logic CMD_READ     = 1'b1;

   localparam logic [7:0] PLAIN_MAP [0:TABLE_LEN-1] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam logic [7:0] SHIFTED_MAP [0:TABLE_LEN-1] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00
   };

   typedef enum logic [1:0] {
      OP_NOP,
      OP_PUSH,
      OP_POP
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  ch;
   } op_type;

   typedef struct packed {
      logic       command;
      logic [7:0] scancode;
      logic       sub_device_nonzero;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       read_valid;
      logic       char_accepted;
      logic       char_dropped;
      logic [7:0] fifo_level;
      logic       data_ready;
   } rsp_type;

endpackage

@@ rtl/kst_front.sv @@
module kst_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kst_pkg::req_type  req_payload,
   output logic              op_valid,
   input  logic              op_ready,
   output kst_pkg::op_type   op_data
);

   logic shift_held_ff, shift_held_in;
   logic caps_on_ff, caps_on_in;
   logic ctrl_held_ff, ctrl_held_in;
   logic accept;
   logic [7:0] code;
   logic [7:0] ch_lookup;
   logic [7:0] ch_caps;
   logic [7:0] ch_final;

   assign req_ready = op_ready;
   assign op_valid  = req_valid;
   assign accept    = req_valid && op_ready;
   assign code      = req_payload.scancode;

   always_comb begin
      if (code < 8'(kst_pkg::TABLE_LEN)) begin
         ch_lookup = shift_held_ff ? kst_pkg::SHIFTED_MAP[code[6:0]]
                                   : kst_pkg::PLAIN_MAP[code[6:0]];
      end else begin
         ch_lookup = 8'h00;
      end

      ch_caps = ch_lookup;
      if (caps_on_ff) begin
         if (ch_lookup >= 8'h61 && ch_lookup <= 8'h7A) begin
            ch_caps = ch_lookup - 8'h20;
         end else if (ch_lookup >= 8'h41 && ch_lookup <= 8'h5A) begin
            ch_caps = ch_lookup + 8'h20;
         end
      end

      // Ctrl with a letter of either case maps to 1..26.
      ch_final = ch_caps;
      if (ctrl_held_ff) begin
         if (ch_caps >= 8'h61 && ch_caps <= 8'h7A) begin
            ch_final = ch_caps - 8'h60;
         end else if (ch_caps >= 8'h41 && ch_caps <= 8'h5A) begin
            ch_final = ch_caps - 8'h40;
         end
      end
   end

   always_comb begin
      shift_held_in = shift_held_ff;
      caps_on_in    = caps_on_ff;
      ctrl_held_in  = ctrl_held_ff;
      op_data.kind  = kst_pkg::OP_NOP;
      op_data.ch    = ch_final;

      if (req_payload.command == kst_pkg::CMD_READ) begin
         if (!req_payload.sub_device_nonzero) begin
            op_data.kind = kst_pkg::OP_POP;
         end
      end else if (code == kst_pkg::SC_LSHIFT_MAKE || code == kst_pkg::SC_RSHIFT_MAKE) begin
         shift_held_in = 1'b1;
      end else if (code == kst_pkg::SC_LSHIFT_BREAK || code == kst_pkg::SC_RSHIFT_BREAK) begin
         shift_held_in = 1'b0;
      end else if (code == kst_pkg::SC_CAPS_MAKE) begin
         caps_on_in = !caps_on_ff;
      end else if (code == kst_pkg::SC_CTRL_MAKE) begin
         ctrl_held_in = 1'b1;
      end else if (code == kst_pkg::SC_CTRL_BREAK) begin
         ctrl_held_in = 1'b0;
      end else if ((code & kst_pkg::SC_BREAK_BIT) == 8'h00 && ch_final != 8'h00) begin
         op_data.kind = kst_pkg::OP_PUSH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_held_ff <= 1'b0;
         caps_on_ff    <= 1'b0;
         ctrl_held_ff  <= 1'b0;
      end else if (accept) begin
         shift_held_ff <= shift_held_in;
         caps_on_ff    <= caps_on_in;
         ctrl_held_ff  <= ctrl_held_in;
      end
   end

endmodule

@@ rtl/kst_queue.sv @@
module kst_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  kst_pkg::op_type  in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output kst_pkg::op_type  out_data
);

   kst_pkg::op_type slot_ff [2];
   logic            head_ff;
   logic            tail_ff;
   logic [1:0]      count_ff, count_in;
   logic            push;
   logic            pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[head_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            tail_ff <= !tail_ff;
         end
         if (pop) begin
            head_ff <= !head_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= in_data;
      end
   end

endmodule

@@ rtl/kst_back.sv @@
module kst_back #(
   parameter int FIFO_DEPTH = kst_pkg::FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_valid,
   output logic             op_ready,
   input  kst_pkg::op_type  op_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kst_pkg::rsp_type rsp_payload
);

   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam int LW = (CW > 8) ? CW : 8;

   logic [7:0]    char_store [FIFO_DEPTH];
   logic [PW-1:0] read_index_ff, read_index_in;
   logic [PW-1:0] write_index_ff, write_index_in;
   logic [CW-1:0] held_count_ff, held_count_in;
   logic [7:0]    rdata_ff;
   logic          rsp_valid_ff;
   logic          read_valid_ff, read_valid_in;
   logic          accepted_ff, accepted_in;
   logic          dropped_ff, dropped_in;
   logic [7:0]    level_ff, level_in;
   logic          data_ready_ff;
   logic          exec;
   logic          do_push;
   logic [LW-1:0] count_wide;

   assign op_ready = !rsp_valid_ff || rsp_ready;
   assign exec     = op_valid && op_ready;

   always_comb begin
      read_index_in  = read_index_ff;
      write_index_in = write_index_ff;
      held_count_in  = held_count_ff;
      read_valid_in  = 1'b0;
      accepted_in    = 1'b0;
      dropped_in     = 1'b0;
      do_push        = 1'b0;

      unique case (op_data.kind)
         kst_pkg::OP_POP: begin
            if (held_count_ff != '0) begin
               read_valid_in = 1'b1;
               read_index_in = (read_index_ff == PW'(FIFO_DEPTH - 1)) ? '0
                                                                      : read_index_ff + 1'b1;
               held_count_in = held_count_ff - 1'b1;
            end
         end
         kst_pkg::OP_PUSH: begin
            if (held_count_ff < CW'(FIFO_DEPTH)) begin
               do_push        = exec;
               accepted_in    = 1'b1;
               write_index_in = (write_index_ff == PW'(FIFO_DEPTH - 1)) ? '0
                                                                        : write_index_ff + 1'b1;
               held_count_in  = held_count_ff + 1'b1;
            end else begin
               dropped_in = 1'b1;
            end
         end
         default: begin
         end
      endcase

      count_wide = LW'(held_count_in);
      level_in   = (count_wide > LW'(255)) ? 8'hFF : count_wide[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_index_ff  <= '0;
         write_index_ff <= '0;
         held_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (exec) begin
            read_index_ff  <= read_index_in;
            write_index_ff <= write_index_in;
            held_count_ff  <= held_count_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         read_valid_ff <= read_valid_in;
         accepted_ff   <= accepted_in;
         dropped_ff    <= dropped_in;
         level_ff      <= level_in;
         data_ready_ff <= (held_count_in != '0);
      end
   end

   // A pop never reads the slot being written: a push only lands when not full.
   always_ff @(posedge clock) begin
      if (do_push) begin
         char_store[write_index_ff] <= op_data.ch;
      end
      if (exec) begin
         rdata_ff <= char_store[read_index_ff];
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_payload.read_data     = read_valid_ff ? rdata_ff : 8'h00;
   assign rsp_payload.read_valid    = read_valid_ff;
   assign rsp_payload.char_accepted = accepted_ff;
   assign rsp_payload.char_dropped  = dropped_ff;
   assign rsp_payload.fifo_level    = level_ff;
   assign rsp_payload.data_ready    = data_ready_ff;

endmodule

@@ rtl/keyboard_scancode_translator_fifo.sv @@
// An accepted transaction is held in the two-entry queue, then registered in the back end's response.
// Throughput: one transaction per cycle while responses are taken; the character store takes one write
// and one registered read per cycle, and a two-entry queue decouples translation.
// Reset clears the modifier flags, FIFO pointers, held count and queue; the character
// store is not cleared and only written entries are ever read.
module keyboard_scancode_translator_fifo #(
   parameter int FIFO_DEPTH = kst_pkg::FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kst_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kst_pkg::rsp_type rsp_payload
);

   logic            fq_valid;
   logic            fq_ready;
   kst_pkg::op_type fq_data;
   logic            qb_valid;
   logic            qb_ready;
   kst_pkg::op_type qb_data;

   kst_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .op_valid    (fq_valid),
      .op_ready    (fq_ready),
      .op_data     (fq_data)
   );

   kst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   kst_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (qb_valid),
      .op_ready    (qb_ready),
      .op_data     (qb_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
